[src/swtr_pkg.sv]
// shared types, constants and handshake structs for the tile residency block
package swtr_pkg;

  // window geometry
  localparam int VIEW_RADIUS = 1;
  localparam int SIDE        = 2 * VIEW_RADIUS + 1;
  localparam int SLOTS       = SIDE * SIDE;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int POS_W       = (SIDE > 1) ? $clog2(SIDE) : 1;

  // field widths
  localparam int CAM_W  = 32;
  localparam int TILE_W = 24;
  localparam int LG_W   = 4;
  localparam int CFG_IDX_W = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH_LOG2 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_DEPTH_LOG2 = CFG_IDX_W'(1);

  localparam logic [LG_W-1:0] LG_RESET = LG_W'(7);

  // input word
  typedef struct packed {
    logic signed [CAM_W-1:0] cam_x;
    logic signed [CAM_W-1:0] cam_z;
  } in_word_t;

  // result word
  typedef struct packed {
    logic signed [TILE_W-1:0] tile_x;
    logic signed [TILE_W-1:0] tile_y;
    logic [3:0]               slot;
    logic                     last;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic take;       // input side open
    logic calc;       // compute centres, clear counters
    logic step;       // advance window position
    logic use_prev;   // walk the previous window, test against new centre
    logic push_gone;  // record current tile as leaving
    logic emit;       // load output register and slot store
    logic emit_fill;  // first-fill emit: slot follows position
    logic finish;     // commit centre, mark window filled
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic filled;
    logic pos_end;
    logic near;
    logic out_free;
  } ctl_sts_t;

endpackage

[src/swtr_ctrl.sv]
// sequencer for the tile residency block
module swtr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  swtr_pkg::ctl_sts_t sts,
  output swtr_pkg::ctl_cmd_t cmd
);
  import swtr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_FILL,
    ST_GONE,
    ST_NEWS,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.take = 1'b1;
        if (in_valid) state_nxt = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = sts.filled ? ST_GONE : ST_FILL;
      end
      ST_FILL: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_fill = 1'b1;
          cmd.step      = 1'b1;
          if (sts.pos_end) state_nxt = ST_DONE;
        end
      end
      ST_GONE: begin
        cmd.use_prev  = 1'b1;
        cmd.step      = 1'b1;
        cmd.push_gone = ~sts.near;
        if (sts.pos_end) state_nxt = ST_NEWS;
      end
      ST_NEWS: begin
        // tiles already resident are skipped
        if (sts.near) begin
          cmd.step = 1'b1;
          if (sts.pos_end) state_nxt = ST_DONE;
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.step = 1'b1;
          if (sts.pos_end) state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[src/swtr_dp.sv]
// datapath: centres, window walk, slot store, leaving list and output register
module swtr_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [swtr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swtr_pkg::LG_W-1:0]      cfg_data,
  input  logic                           in_valid,
  input  swtr_pkg::in_word_t             in_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output swtr_pkg::out_word_t            out_word,
  input  swtr_pkg::ctl_cmd_t             cmd,
  output swtr_pkg::ctl_sts_t             sts
);
  import swtr_pkg::*;

  localparam logic signed [TILE_W-1:0] RAD = TILE_W'(VIEW_RADIUS);

  // centre tile, rounded half away from zero
  function automatic logic [TILE_W-1:0] centre_of(logic [CAM_W-1:0] raw, logic [LG_W-1:0] lg);
    logic        neg;
    logic [32:0] mag;
    logic [4:0]  s;
    logic [33:0] sum;
    logic [33:0] q;
    neg = raw[CAM_W-1];
    mag = neg ? (33'h1_0000_0000 - {1'b0, raw}) : {1'b0, raw};
    s   = {1'b0, lg} + 5'd8;
    sum = {1'b0, mag} + (34'd1 << (s - 5'd1));
    q   = sum >> s;
    return neg ? (TILE_W'(0) - q[TILE_W-1:0]) : q[TILE_W-1:0];
  endfunction

  // wrapped distance within the radius
  function automatic logic near_axis(logic [TILE_W-1:0] t, logic [TILE_W-1:0] c);
    logic signed [TILE_W-1:0] d;
    d = $signed(t - c);
    return (d >= -RAD) && (d <= RAD);
  endfunction

  logic [LG_W-1:0]   lg_x_r, lg_z_r;
  in_word_t          cam_r;
  logic              filled_r;
  logic [TILE_W-1:0] cen_x_r, cen_y_r;
  logic [TILE_W-1:0] prev_x_r, prev_y_r;
  logic [POS_W-1:0]  col_r, row_r;
  logic [CNT_W-1:0]  gone_n_r, head_r;
  logic [TILE_W-1:0] store_x_r [SLOTS];
  logic [TILE_W-1:0] store_y_r [SLOTS];
  logic [TILE_W-1:0] gone_x_r  [SLOTS];
  logic [TILE_W-1:0] gone_y_r  [SLOTS];
  out_word_t         out_r;
  logic              out_valid_r, out_valid_nxt;

  logic [TILE_W-1:0] base_x, base_y, ref_x, ref_y, tile_x, tile_y;
  logic [TILE_W-1:0] gx, gy;
  logic [SLOT_W-1:0] pos_idx, match_slot, wr_slot;
  logic              pos_end, head_last;

  // current window position and its tile
  always_comb begin
    base_x  = cmd.use_prev ? prev_x_r : cen_x_r;
    base_y  = cmd.use_prev ? prev_y_r : cen_y_r;
    ref_x   = cmd.use_prev ? cen_x_r : prev_x_r;
    ref_y   = cmd.use_prev ? cen_y_r : prev_y_r;
    tile_x  = base_x + (TILE_W'(col_r) - TILE_W'(VIEW_RADIUS));
    tile_y  = base_y + (TILE_W'(row_r) - TILE_W'(VIEW_RADIUS));
    pos_end = (col_r == POS_W'(SIDE - 1)) && (row_r == POS_W'(SIDE - 1));
    pos_idx = SLOT_W'(int'(row_r) * SIDE + int'(col_r));
  end

  // slot of the next leaving tile, first match wins, slot 0 if none
  always_comb begin
    gx         = gone_x_r[head_r[SLOT_W-1:0]];
    gy         = gone_y_r[head_r[SLOT_W-1:0]];
    match_slot = '0;
    if (head_r < gone_n_r) begin
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (store_x_r[i] == gx && store_y_r[i] == gy) match_slot = SLOT_W'(i);
      end
    end
    head_last = (CNT_W'(head_r + CNT_W'(1)) == gone_n_r);
    wr_slot   = cmd.emit_fill ? pos_idx : match_slot;
  end

  // output register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit)      out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg_x_r <= LG_RESET;
      lg_z_r <= LG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TILE_WIDTH_LOG2: lg_x_r <= cfg_data;
        CFG_TILE_DEPTH_LOG2: lg_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // control state of the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r    <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      col_r       <= '0;
      row_r       <= '0;
      gone_n_r    <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.calc) begin
        col_r    <= '0;
        row_r    <= '0;
        gone_n_r <= '0;
        head_r   <= '0;
      end
      if (cmd.step) begin
        if (col_r == POS_W'(SIDE - 1)) begin
          col_r <= '0;
          row_r <= pos_end ? '0 : POS_W'(row_r + POS_W'(1));
        end else begin
          col_r <= POS_W'(col_r + POS_W'(1));
        end
      end
      if (cmd.push_gone) gone_n_r <= CNT_W'(gone_n_r + CNT_W'(1));
      if (cmd.emit && !cmd.emit_fill) head_r <= CNT_W'(head_r + CNT_W'(1));
      if (cmd.finish) begin
        filled_r <= 1'b1;
        prev_x_r <= cen_x_r;
        prev_y_r <= cen_y_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take && in_valid) cam_r <= in_word;
    if (cmd.calc) begin
      cen_x_r <= centre_of(cam_r.cam_x, lg_x_r);
      cen_y_r <= centre_of(cam_r.cam_z, lg_z_r);
    end
    if (cmd.push_gone) begin
      gone_x_r[gone_n_r[SLOT_W-1:0]] <= tile_x;
      gone_y_r[gone_n_r[SLOT_W-1:0]] <= tile_y;
    end
    if (cmd.emit) begin
      store_x_r[wr_slot] <= tile_x;
      store_y_r[wr_slot] <= tile_y;
      out_r.tile_x       <= $signed(tile_x);
      out_r.tile_y       <= $signed(tile_y);
      out_r.slot         <= 4'(wr_slot);
      out_r.last         <= cmd.emit_fill ? pos_end : head_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_word     = out_r;
  assign sts.filled   = filled_r;
  assign sts.pos_end  = pos_end;
  assign sts.near     = near_axis(tile_x, ref_x) && near_axis(tile_y, ref_y);
  assign sts.out_free = ~out_valid_r | ~out_stall;

endmodule

[src/sliding_window_tile_residency.sv]
// top level of the sliding window tile residency tracker
// Each camera word is taken only while the block is idle. A calculation state computes the
// centre tile on both axes, then a sequencer walks the window one position per cycle,
// holding while an emit waits on a stalled output: a first word loads the whole window
// (9 results, one per cycle while the output is free), a later word walks the old window
// once to list leaving tiles and the new window once to emit entering ones, each entering
// tile finding its slot in the same cycle by comparing against all slots. A word whose
// centre is unchanged yields no result. The next word is accepted while the final result
// still waits in the output register.
module sliding_window_tile_residency (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [swtr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swtr_pkg::LG_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  swtr_pkg::in_word_t             in_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output swtr_pkg::out_word_t            out_word
);
  import swtr_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // sequencer
  swtr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  swtr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cmd       (cmd),
    .sts       (sts)
  );

  assign in_stall = ~cmd.take;

endmodule

[src/swtr_chk.sv]
// port-level checker for the tile residency block, bound to the top level
module swtr_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input swtr_pkg::out_word_t out_word
);
  import swtr_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // busy right after taking a word
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while still working");

  // no result can appear the cycle after a word is taken
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result before centre computed");

  // slot stays inside the window
  a_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.slot < 4'(SLOTS)))
    else $error("slot out of range");

endmodule

bind sliding_window_tile_residency swtr_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

[dv/sliding_window_tile_residency_tb.sv]
// self-checking testbench for the sliding window tile residency tracker
module sliding_window_tile_residency_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swtr_pkg::*;

  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASES          = 6;
  localparam int PHASE_WORDS     = 35;

  // register index that decodes to nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = CFG_IDX_W'(9);

  typedef enum logic [0:0] {ROW_CAM, ROW_CFG} row_kind_t;

  // one directed row: a camera word, or a register write (a = index, b = value)
  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] a;
    logic [31:0] b;
    logic        typed;
    logic [3:0]  n_loads;
    logic [23:0] first_x;
    logic [23:0] first_y;
    logic [3:0]  first_slot;
  } dir_row_t;

  localparam int N_DIR = 23;
  localparam dir_row_t DIR_ROWS [0:N_DIR-1] = '{
    // first word after reset loads the full window around tile (0,0)
    '{ROW_CAM, 32'h0000_0000, 32'h0000_0000, 1'b1, 4'd9, 24'hFFFFFF, 24'hFFFFFF, 4'd0},
    // small offset, centre unchanged
    '{ROW_CAM, 32'h0000_0064, 32'hFFFF_FF9C, 1'b1, 4'd0, 24'h0, 24'h0, 4'd0},
    // one tile right: a column enters and takes the slot of (-1,-1)
    '{ROW_CAM, 32'h0000_8000, 32'h0000_0000, 1'b1, 4'd3, 24'h000002, 24'hFFFFFF, 4'd0},
    // exactly half a tile rounds up, so still centre 1
    '{ROW_CAM, 32'h0000_4000, 32'h0000_0000, 1'b1, 4'd0, 24'h0, 24'h0, 4'd0},
    '{ROW_CAM, 32'h0000_3FFF, 32'h0000_0000, 1'b0, 4'd0, 24'h0, 24'h0, 4'd0},
    // negative half rounds away from zero
    '{ROW_CAM, 32'hFFFF_C000, 32'hFFFF_C000, 1'b0, 4'd0, 24'h0, 24'h0, 4'd0},
    '{ROW_CAM, 32'hFFFF_C001, 32'h0000_3FFF, 1'b0, 4'd0, 24'h0, 24'h0, 4'd0},
    // position extremes, full window replaced
    '{ROW_CAM, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 4'd0, 24'h0, 24'h0, 4'd0},
    '{ROW_CAM, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 4'd0, 24'h0, 24'h0, 4'd0},
    '{ROW_CFG, 32'(CFG_TILE_WIDTH_LOG2), 32'd0, 1'b0, 4'd0, 24'h0, 24'h0, 4'd0},
    '{ROW_CFG, 32'(CFG_TILE_DEPTH_LOG2), 32'd0, 1'b0, 4'd0, 24'h0, 24'h0, 4'd0},
    // smallest tiles: centre wraps to the most negative tile index
    '{ROW_CAM, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 4'd0, 24'h0, 24'h0, 4'd0},
    '{ROW_CAM, 32'h8000_0000, 32'h8000_0000, 1'b1, 4'd0, 24'h0, 24'h0, 4'd0},
    // step across the 24-bit wrap on x
    '{ROW_CAM, 32'h7FFF_FF7F, 32'h8000_0000, 1'b0, 4'd0, 24'h0, 24'h0, 4'd0},
    '{ROW_CFG, 32'(CFG_TILE_WIDTH_LOG2), 32'd15, 1'b0, 4'd0, 24'h0, 24'h0, 4'd0},
    '{ROW_CFG, 32'(CFG_TILE_DEPTH_LOG2), 32'd15, 1'b0, 4'd0, 24'h0, 24'h0, 4'd0},
    '{ROW_CAM, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 4'd0, 24'h0, 24'h0, 4'd0},
    // write to an unused index must leave both sizes alone
    '{ROW_CFG, 32'(CFG_UNUSED_IDX), 32'd3, 1'b0, 4'd0, 24'h0, 24'h0, 4'd0},
    '{ROW_CAM, 32'h00C0_0000, 32'h0000_0000, 1'b0, 4'd0, 24'h0, 24'h0, 4'd0},
    '{ROW_CFG, 32'(CFG_TILE_WIDTH_LOG2), 32'd7, 1'b0, 4'd0, 24'h0, 24'h0, 4'd0},
    '{ROW_CFG, 32'(CFG_TILE_DEPTH_LOG2), 32'd3, 1'b0, 4'd0, 24'h0, 24'h0, 4'd0},
    // straight move, then a diagonal one
    '{ROW_CAM, 32'h0001_0000, 32'h0000_0800, 1'b0, 4'd0, 24'h0, 24'h0, 4'd0},
    '{ROW_CAM, 32'h0001_8000, 32'h0000_1000, 1'b0, 4'd0, 24'h0, 24'h0, 4'd0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LG_W-1:0]      cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_word_t             in_word = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_word;

  sliding_window_tile_residency dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [LG_W-1:0] lg_x, lg_z;
  logic [23:0]     slot_x [SLOTS];
  logic [23:0]     slot_y [SLOTS];
  logic [23:0]     prev_cx, prev_cy;
  bit              window_full;

  out_word_t   step_loads [$];
  out_word_t   pending_loads [$];
  int unsigned fail_count = 0;
  int unsigned words_sent = 0;
  int unsigned loads_seen = 0;
  int unsigned reg_writes = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  bit          hold_off_req = 1'b0;
  bit          hold_off_done = 1'b0;

  // centre tile: divide by 2^(lg+8), round half away from zero, keep 24 bits
  function automatic logic [23:0] centre_tile(logic [31:0] raw, logic [LG_W-1:0] lg);
    logic [32:0] mag;
    logic [32:0] q;
    int unsigned sh;
    sh  = int'(lg) + 8;
    mag = raw[31] ? (33'h1_0000_0000 - {1'b0, raw}) : {1'b0, raw};
    q   = (mag + (33'd1 << (sh - 1))) >> sh;
    return raw[31] ? (24'd0 - q[23:0]) : q[23:0];
  endfunction

  function automatic bit near_tile(logic [23:0] t, logic [23:0] c);
    logic signed [23:0] d;
    d = t - c;
    return (d >= -VIEW_RADIUS) && (d <= VIEW_RADIUS);
  endfunction

  function automatic void store_load(logic [23:0] tx, logic [23:0] ty, int slot);
    out_word_t ld;
    ld.tile_x = tx;
    ld.tile_y = ty;
    ld.slot   = 4'(slot);
    ld.last   = 1'b0;
    step_loads = {step_loads, ld};
    slot_x[slot] = tx;
    slot_y[slot] = ty;
  endfunction

  // queue the loads of the latest word behind those still expected
  function automatic void append_loads();
    pending_loads = {pending_loads, step_loads};
  endfunction

  // tile loads caused by one camera word, left in step_loads
  function automatic void predict_loads(in_word_t w);
    logic [23:0] cx, cy, tx, ty;
    logic [23:0] gone_x [SLOTS];
    logic [23:0] gone_y [SLOTS];
    int          gone_n, head, slot;
    bit          found;
    cx = centre_tile(w.cam_x, lg_x);
    cy = centre_tile(w.cam_z, lg_z);
    gone_n = 0;
    head = 0;
    step_loads.delete();
    if (!window_full) begin
      for (int yo = -VIEW_RADIUS; yo <= VIEW_RADIUS; yo++)
        for (int xo = -VIEW_RADIUS; xo <= VIEW_RADIUS; xo++)
          store_load(cx + 24'(xo), cy + 24'(yo), step_loads.size());
      window_full = 1'b1;
    end else begin
      // tiles of the old window that fall out, in old row-major order
      for (int yo = -VIEW_RADIUS; yo <= VIEW_RADIUS; yo++)
        for (int xo = -VIEW_RADIUS; xo <= VIEW_RADIUS; xo++) begin
          tx = prev_cx + 24'(xo);
          ty = prev_cy + 24'(yo);
          if (!(near_tile(tx, cx) && near_tile(ty, cy))) begin
            gone_x[gone_n] = tx;
            gone_y[gone_n] = ty;
            gone_n++;
          end
        end
      // entering tiles take freed slots in turn
      for (int yo = -VIEW_RADIUS; yo <= VIEW_RADIUS; yo++)
        for (int xo = -VIEW_RADIUS; xo <= VIEW_RADIUS; xo++) begin
          tx = cx + 24'(xo);
          ty = cy + 24'(yo);
          if (!(near_tile(tx, prev_cx) && near_tile(ty, prev_cy))) begin
            slot = 0;
            if (head < gone_n) begin
              found = 1'b0;
              for (int i = 0; i < SLOTS; i++)
                if (!found && slot_x[i] == gone_x[head] && slot_y[i] == gone_y[head]) begin
                  slot = i;
                  found = 1'b1;
                end
              head++;
            end
            store_load(tx, ty, slot);
          end
        end
    end
    prev_cx = cx;
    prev_cy = cy;
    if (step_loads.size() > 0)
      step_loads[step_loads.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: tile load %0d, %s expected %0h got %0h", $time, loads_seen, name,
               want, got);
    end
  endfunction

  // offers one camera word, returns at the edge that takes it
  task automatic send_cam(input in_word_t w);
    int unsigned gap;
    bit          taken;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
    end
    burst_left--;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    words_sent++;
  endtask

  // waits until every expected load has come and the block has settled
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_loads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LG_W-1:0] val);
    drain_block();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_TILE_WIDTH_LOG2)
      lg_x = val;
    else if (idx == CFG_TILE_DEPTH_LOG2)
      lg_z = val;
    reg_writes++;
  endtask

  // random offset of up to quarters/4 tiles either way
  function automatic int jitter(logic [LG_W-1:0] lg, int unsigned quarters);
    int span;
    span = ((1 << (int'(lg) + 8)) / 4) * int'(quarters);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // stimulus
  initial begin : stimulus
    in_word_t    w;
    in_word_t    pos;
    dir_row_t    row;
    int unsigned pick;
    lg_x = LG_RESET;
    lg_z = LG_RESET;
    prev_cx = '0;
    prev_cy = '0;
    window_full = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int r = 0; r < N_DIR; r++) begin
      row = DIR_ROWS[r];
      if (row.kind == ROW_CFG) begin
        write_reg(row.a[CFG_IDX_W-1:0], row.b[LG_W-1:0]);
      end else begin
        w.cam_x = row.a;
        w.cam_z = row.b;
        send_cam(w);
        predict_loads(w);
        if (row.typed) begin
          if (step_loads.size() != int'(row.n_loads)) begin
            fail_count++;
            $display("%0t: directed row %0d expected %0d loads, predicted %0d", $time, r,
                     row.n_loads, step_loads.size());
          end else if (row.n_loads != 0) begin
            step_loads[0].tile_x = row.first_x;
            step_loads[0].tile_y = row.first_y;
            step_loads[0].slot   = row.first_slot;
          end
        end
        append_loads();
      end
    end

    // random phases, each with its own tile sizes
    pos = '0;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          write_reg(CFG_TILE_WIDTH_LOG2, 4'd0);
          write_reg(CFG_TILE_DEPTH_LOG2, 4'd15);
        end
        1: begin
          write_reg(CFG_TILE_WIDTH_LOG2, 4'd15);
          write_reg(CFG_TILE_DEPTH_LOG2, 4'd0);
        end
        default: begin
          write_reg(CFG_TILE_WIDTH_LOG2, LG_W'($urandom_range(0, 15)));
          write_reg(CFG_TILE_DEPTH_LOG2, LG_W'($urandom_range(0, 15)));
        end
      endcase
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (p == 2 && k == 20)
          hold_off_req = 1'b1;
        if (p == 4 && k == 17)
          drain_block();
        pick = $urandom_range(0, 9);
        if (pick <= 6) begin
          // walk a tile or two
          pos.cam_x = pos.cam_x + jitter(lg_x, 8);
          pos.cam_z = pos.cam_z + jitter(lg_z, 8);
        end else if (pick == 7) begin
          // jiggle, mostly inside the same tile
          pos.cam_x = pos.cam_x + jitter(lg_x, 1);
          pos.cam_z = pos.cam_z + jitter(lg_z, 1);
        end else begin
          pos.cam_x = $urandom;
          pos.cam_z = $urandom;
        end
        send_cam(pos);
        predict_loads(pos);
        append_loads();
      end
    end

    in_valid <= 1'b0;
    while (pending_loads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d camera words, %0d checked tile loads, %0d register writes",
             words_sent, loads_seen, reg_writes);
    $display("sizes swept 0..15 per axis, 24-bit tile wrap, long output hold-off");
    if (fail_count == 0)
      $display("sliding_window_tile_residency_tb OK");
    else
      $display("sliding_window_tile_residency_tb NOT OK");
    $finish;
  end

  // receiver: stall modes that change at random, one long hold-off on request
  initial begin : receiver
    int unsigned mode;
    int unsigned left;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 80);
      end
      left--;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= 1'($urandom_range(0, 1));
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // result checker and watchdog, sampled mid-cycle where everything is settled
  always @(negedge clk) begin
    out_word_t want;
    if (rst_n) begin
      idle_cycles++;
      if (in_valid && !in_stall)
        idle_cycles = 0;
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        idle_cycles = 0;
        if (pending_loads.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected tile load, expected none got x=%0h y=%0h slot=%0d",
                   $time, out_word.tile_x, out_word.tile_y, out_word.slot);
        end else begin
          want = pending_loads.pop_front();
          check_field("tile_x", want.tile_x, out_word.tile_x);
          check_field("tile_y", want.tile_y, out_word.tile_y);
          check_field("slot", 24'(want.slot), 24'(out_word.slot));
          check_field("last", 24'(want.last), 24'(out_word.last));
        end
        loads_seen++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles, %0d loads outstanding", $time,
                 WATCHDOG_LIMIT, pending_loads.size());
        $display("sliding_window_tile_residency_tb NOT OK");
        $finish;
      end
    end
  end

endmodule
